// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the route lookup RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define RPL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("route lookup assertion failed");

// Condition must never be seen at a rising edge outside reset.
`define RPL_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("route lookup forbidden condition seen");

`endif

// ===== hdl/rpl_pkg.sv =====
// Types and constants of the route prefix lookup block.
// No dependencies; imported by rpl_cell, route_prefix_lookup and the bench.
`timescale 1ns / 1ps
`default_nettype none

package rpl_pkg;

  localparam int unsigned Depth  = 16;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned PortW  = 4;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned CountW = 5;
  localparam int unsigned StatW  = 2;
  localparam int unsigned PosW   = 9;
  localparam int unsigned InDataW  = 136;
  localparam int unsigned OutDataW = 40;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic [StatW-1:0] STAT_WRITE = 2'd0;
  localparam logic [StatW-1:0] STAT_FOUND = 2'd1;
  localparam logic [StatW-1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_HOLD
  } state_e;

  // table write broadcast to every cell
  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] idx;
    logic [AddrW-1:0] prefix;
    logic [AddrW-1:0] mask;
    logic [AddrW-1:0] gateway;
    logic [PortW-1:0] port;
  } wr_t;

  // lookup token handed from cell to cell
  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] mask;
    logic [AddrW-1:0] gateway;
    logic [PortW-1:0] port;
    logic [SlotW-1:0] idx;
  } tok_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [SlotW-1:0] idx;
    logic [AddrW-1:0] next_hop;
    logic [PortW-1:0] port;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/rpl_cell.sv =====
// One route table slot and its compare stage in the lookup chain.
// Depends on rpl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpl_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  rpl_pkg::wr_t               wr_i,
  input  wire  [rpl_pkg::CountW-1:0] cnt_i,
  input  wire                        vld_i,
  input  rpl_pkg::tok_t              tok_i,
  output logic                       vld_o,
  output rpl_pkg::tok_t              tok_o
);
  import rpl_pkg::*;

  localparam logic [PosW-1:0] CellPos = PosW'(CELL_IDX);
  localparam bit IsFirst = (CELL_IDX == 0);

  logic [AddrW-1:0] prefix_q;
  logic [AddrW-1:0] mask_q;
  logic [AddrW-1:0] gateway_q;
  logic [PortW-1:0] port_q;

  logic wr_hit;
  logic active;
  logic take;
  logic vld_q;
  tok_t tok_d;
  tok_t tok_q;

  assign wr_hit = wr_i.en && ({{(PosW-SlotW){1'b0}}, wr_i.idx} == CellPos);
  assign active = {{(PosW-CountW){1'b0}}, cnt_i} > CellPos;
  assign take   = IsFirst || (active && ((tok_i.addr & mask_q) == prefix_q)
                                      && (mask_q > tok_i.mask));

  always_comb begin
    tok_d = tok_i;
    if (take) begin
      tok_d.mask    = mask_q;
      tok_d.gateway = gateway_q;
      tok_d.port    = port_q;
      tok_d.idx     = CellPos[SlotW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      prefix_q  <= wr_i.prefix;
      mask_q    <= wr_i.mask;
      gateway_q <= wr_i.gateway;
      port_q    <= wr_i.port;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign vld_o = vld_q;
  assign tok_o = tok_q;

endmodule

`default_nettype wire

// ===== hdl/route_prefix_lookup.sv =====
// Lookup: an accepted lookup walks the chain, then its result is registered in
// res_q, then in out_q; a write item or an empty table goes straight to res_q.
// One item is in flight at a time. The walk moves one lookup token a cell per
// cycle through Depth slot cells, so the chain length sets the lookup time.
// Reset (rst_ni low, asynchronous) clears control state and the route count;
// table contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module route_prefix_lookup (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [rpl_pkg::CountW-1:0]   cfg_wdata_i,
  input  wire                          s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // entry_index, entry_prefix, entry_mask, entry_gateway, entry_port,
  // lookup_address
  input  wire  [rpl_pkg::InDataW-1:0]  s_axis_tdata_i,
  // func
  input  wire                          s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  wire                          m_axis_tready_i,
  // route_index, next_hop, out_port
  output logic [rpl_pkg::OutDataW-1:0] m_axis_tdata_o,
  // status
  output logic [rpl_pkg::StatW-1:0]    m_axis_tuser_o
);
  import rpl_pkg::*;

  state_e state_q, state_d;
  logic [CountW-1:0] cfg_q;
  res_t res_q, res_d;
  res_t out_q, out_d;
  logic out_vld_q, out_vld_d;

  logic acc;
  logic out_free;
  logic inj_vld;
  wr_t  wr;
  tok_t inj_tok;

  logic vld [0:Depth];
  tok_t tok [0:Depth];
  logic [Depth-1:0] chain_vld;

  assign acc      = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_vld_q || m_axis_tready_i;

  assign wr.en      = acc && (s_axis_tuser_i == FUNC_WRITE);
  assign wr.idx     = s_axis_tdata_i[3:0];
  assign wr.prefix  = s_axis_tdata_i[35:4];
  assign wr.mask    = s_axis_tdata_i[67:36];
  assign wr.gateway = s_axis_tdata_i[99:68];
  assign wr.port    = s_axis_tdata_i[103:100];

  assign inj_vld = acc && (s_axis_tuser_i == FUNC_LOOKUP) && (cfg_q != '0);
  always_comb begin
    inj_tok      = '0;
    inj_tok.addr = s_axis_tdata_i[135:104];
  end

  assign vld[0] = inj_vld;
  assign tok[0] = inj_tok;

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    rpl_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .wr_i  (wr),
      .cnt_i (cfg_q),
      .vld_i (vld[g]),
      .tok_i (tok[g]),
      .vld_o (vld[g+1]),
      .tok_o (tok[g+1])
    );
    assign chain_vld[g] = vld[g+1];
  end

  always_comb begin
    state_d   = state_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !m_axis_tready_i;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (acc) begin
          if (s_axis_tuser_i == FUNC_WRITE) begin
            res_d        = '0;
            res_d.status = STAT_WRITE;
            state_d      = ST_HOLD;
          end else if (cfg_q == '0) begin
            res_d        = '0;
            res_d.status = STAT_EMPTY;
            state_d      = ST_HOLD;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (vld[Depth]) begin
          res_d.status   = STAT_FOUND;
          res_d.idx      = tok[Depth].idx;
          res_d.next_hop = tok[Depth].gateway;
          res_d.port     = tok[Depth].port;
          state_d        = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      cfg_q     <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {out_q.port, out_q.next_hop, out_q.idx};

  `RPL_ASSERT(a_one_item, clk_i, rst_ni, acc |=> !s_axis_tready_o)
  `RPL_ASSERT(a_one_token, clk_i, rst_ni, $onehot0(chain_vld))
  `RPL_ASSERT_NEVER(a_tail_walk, clk_i, rst_ni, vld[Depth] && (state_q != ST_WALK))

endmodule

`default_nettype wire

// ===== verif/route_prefix_lookup_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for route_prefix_lookup: table writes and address lookups
// go in over the input stream, each answer is compared with an in-bench route model.
// Depends on rpl_pkg and the route_prefix_lookup RTL.
module route_prefix_lookup_tb;
  import rpl_pkg::*;

  localparam int unsigned NumPhases = 10;

  typedef struct {
    logic             func;
    logic [SlotW-1:0] slot;
    logic [AddrW-1:0] prefix;
    logic [AddrW-1:0] mask;
    logic [AddrW-1:0] gateway;
    logic [PortW-1:0] port;
    logic [AddrW-1:0] addr;
  } route_item_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CountW-1:0]   cfg_wdata_i = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic                s_axis_tuser_i = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [StatW-1:0]    m_axis_tuser_o;

  // route model state
  logic [AddrW-1:0] route_prefix[Depth];
  logic [AddrW-1:0] route_mask[Depth];
  logic [AddrW-1:0] route_gateway[Depth];
  logic [PortW-1:0] route_port[Depth];
  int unsigned      active_routes = 0;

  // table contents as seen by the item generator
  logic [AddrW-1:0] gen_prefix[Depth];
  logic [AddrW-1:0] gen_mask[Depth];

  route_item_t pending_items[$];
  res_t        expected_routes[$];
  route_item_t next_item;
  route_item_t taken_item;
  res_t        want;
  logic [SlotW-1:0] got_slot;
  logic [AddrW-1:0] got_hop;
  logic [PortW-1:0] got_port;

  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned errors = 0;
  int unsigned stall_requests = 0;
  int unsigned stall_served = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned ready_roll;
  bit          gaps_on = 1'b1;
  bit          in_taken = 1'b0;
  int unsigned route_counts[NumPhases] = '{16, 2, 31, 0, 17, 16, 9, 1, 16, 12};

  route_prefix_lookup dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic res_t lookup_route(route_item_t it);
    res_t        r;
    int unsigned count;
    int unsigned best;
    r = '0;
    if (it.func == FUNC_WRITE) begin
      route_prefix[it.slot]  = it.prefix;
      route_mask[it.slot]    = it.mask;
      route_gateway[it.slot] = it.gateway;
      route_port[it.slot]    = it.port;
      r.status = STAT_WRITE;
      return r;
    end
    count = (active_routes > Depth) ? Depth : active_routes;
    if (count == 0) begin
      r.status = STAT_EMPTY;
      return r;
    end
    best = 0;
    for (int unsigned i = 1; i < count; i++) begin
      if ((it.addr & route_mask[i]) == route_prefix[i] && route_mask[i] > route_mask[best]) begin
        best = i;
      end
    end
    r.status   = STAT_FOUND;
    r.idx      = best[SlotW-1:0];
    r.next_hop = route_gateway[best];
    r.port     = route_port[best];
    return r;
  endfunction

  function automatic route_item_t mk_write(logic [SlotW-1:0] slot, logic [AddrW-1:0] prefix,
                                           logic [AddrW-1:0] mask, logic [AddrW-1:0] gateway,
                                           logic [PortW-1:0] port);
    route_item_t it;
    it.func    = FUNC_WRITE;
    it.slot    = slot;
    it.prefix  = prefix;
    it.mask    = mask;
    it.gateway = gateway;
    it.port    = port;
    it.addr    = $urandom;
    return it;
  endfunction

  function automatic route_item_t mk_lookup(logic [AddrW-1:0] addr);
    route_item_t it;
    it.func    = FUNC_LOOKUP;
    it.slot    = SlotW'($urandom_range(0, Depth - 1));
    it.prefix  = $urandom;
    it.mask    = $urandom;
    it.gateway = $urandom;
    it.port    = PortW'($urandom_range(0, 15));
    it.addr    = addr;
    return it;
  endfunction

  // mostly aligned prefixes with contiguous masks, lookups aimed at stored routes
  function automatic route_item_t random_route_item();
    route_item_t it;
    int unsigned roll;
    int unsigned len;
    int unsigned k;
    it = mk_lookup($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      it.func = FUNC_WRITE;
      if (roll >= 3) begin
        len = $urandom_range(0, AddrW);
        it.mask = (len == 0) ? '0 : ({AddrW{1'b1}} << (AddrW - len));
        it.prefix = it.prefix & it.mask;
      end
    end else begin
      k = $urandom_range(0, Depth - 1);
      if (roll < 80) begin
        it.addr = (gen_prefix[k] & gen_mask[k]) | (it.addr & ~gen_mask[k]);
      end else if (roll < 84) begin
        it.addr = '0;
      end else if (roll < 88) begin
        it.addr = '1;
      end
    end
    return it;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!gaps_on) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end
    if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_item(route_item_t it);
    if (it.func == FUNC_WRITE) begin
      gen_prefix[it.slot] = it.prefix;
      gen_mask[it.slot]   = it.mask;
    end
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic drain();
    while (items_taken != items_queued || expected_routes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (Depth + 4) @(posedge clk_i);
  endtask

  task automatic set_routes(logic [CountW-1:0] count);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= count;
    active_routes = count;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic check_field(string name, logic [AddrW-1:0] exp_val, logic [AddrW-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
      errors++;
    end
  endtask

  // sender: hold the item until taken, then idle for a random gap
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_items.size() != 0) begin
        next_item = pending_items.pop_front();
        s_axis_tdata_i <= {next_item.addr, next_item.port, next_item.gateway,
                           next_item.mask, next_item.prefix, next_item.slot};
        s_axis_tuser_i <= next_item.func;
        s_axis_tvalid_i <= 1'b1;
        gap_left = pick_gap();
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver: random back-pressure, plus long holds on request
  always @(negedge clk_i) begin
    if (stall_served != stall_requests) begin
      stall_served = stall_requests;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (!gaps_on) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 3) begin
        hold_left = $urandom_range(8, 40);
      end
      m_axis_tready_i <= (ready_roll >= 30);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        {got_port, got_hop, got_slot} = m_axis_tdata_o;
        if (expected_routes.size() == 0) begin
          $error("unexpected route result: status %0d, slot %0d", m_axis_tuser_o, got_slot);
          errors++;
        end else begin
          want = expected_routes.pop_front();
          check_field("status", want.status, m_axis_tuser_o);
          check_field("route_index", want.idx, got_slot);
          check_field("next_hop", want.next_hop, got_hop);
          check_field("out_port", want.port, got_port);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        {taken_item.addr, taken_item.port, taken_item.gateway,
         taken_item.mask, taken_item.prefix, taken_item.slot} = s_axis_tdata_i;
        taken_item.func = s_axis_tuser_i;
        expected_routes.push_back(lookup_route(taken_item));
        items_taken++;
      end
    end
    in_taken <= rst_ni && s_axis_tvalid_i && s_axis_tready_o;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table straight after reset
    queue_item(mk_lookup('0));
    queue_item(mk_lookup('1));
    // fill every slot: fallback, nested prefixes, a tie, a default route, a host route
    queue_item(mk_write(4'd0, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_0001, 4'd0));
    queue_item(mk_write(4'd1, 32'hC0A8_0000, 32'hFFFF_0000, 32'hC0A8_0001, 4'd1));
    queue_item(mk_write(4'd2, 32'hC0A8_0100, 32'hFFFF_FF00, 32'hC0A8_0101, 4'd2));
    queue_item(mk_write(4'd3, 32'hC0A8_0100, 32'hFFFF_FF00, 32'hC0A8_01FE, 4'd3));
    queue_item(mk_write(4'd4, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'd4));
    for (int s = 5; s < 15; s++) begin
      queue_item(mk_write(SlotW'(s), 32'hAC10_0000 + (s << 8), 32'hFFFF_FF00, $urandom,
                          PortW'(s)));
    end
    queue_item(mk_write(4'd15, '1, '1, '1, 4'd15));

    set_routes(16);
    queue_item(mk_lookup(32'hFFFF_FFFF));
    queue_item(mk_lookup(32'hC0A8_0105));
    queue_item(mk_lookup(32'hC0A8_0205));
    queue_item(mk_lookup(32'h0B00_0000));
    set_routes(31);
    queue_item(mk_lookup(32'hFFFF_FFFF));
    set_routes(1);
    queue_item(mk_lookup(32'hC0A8_0105));

    for (int p = 0; p < NumPhases; p++) begin
      gaps_on = (p % 3 != 1);
      set_routes((p == 6) ? CountW'($urandom_range(3, 15)) : CountW'(route_counts[p]));
      // hold the receiver off while items keep coming
      if (p == 2) begin
        stall_requests++;
      end
      repeat (148) queue_item(random_route_item());
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== route_prefix_lookup.f =====
+incdir+hdl
hdl/rpl_pkg.sv
hdl/rpl_cell.sv
hdl/route_prefix_lookup.sv
verif/route_prefix_lookup_tb.sv
